[rtl/core/lpbd_pkg.sv]
// ---------------------------------------------------------------------------
// lpbd_pkg
// Shared types and constants of the length-prefixed bit deframer: request
// and response payloads and configuration register indexes.
// ---------------------------------------------------------------------------
package lpbd_pkg;

   localparam int BITS_PER_BYTE     = 8;
   localparam int HDR_BYTES_WIDTH   = 3;
   localparam int TOTAL_BITS_WIDTH  = 32;
   localparam int CSR_DATA_WIDTH    = 32;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_HEADER_BYTES = 1'b0,
      CSR_TOTAL_BITS   = 1'b1
   } csr_index_type;

   // one message bit per request
   typedef struct packed {
      logic data_bit;
      logic message_start;
   } req_type;

   // one payload bit per response
   typedef struct packed {
      logic payload_bit;
      logic record_last;
   } rsp_type;

   // parser result toward the output stage
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

[rtl/core/lpbd_parser.sv]
// ---------------------------------------------------------------------------
// lpbd_parser
// Record parser: gathers each length header, checks it against the message
// length and passes payload bits on, one bit per accepted request.
// ---------------------------------------------------------------------------
module lpbd_parser #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  lpbd_pkg::req_type                         req,
   input  logic [lpbd_pkg::HDR_BYTES_WIDTH-1:0]      header_bytes,
   input  logic [lpbd_pkg::TOTAL_BITS_WIDTH-1:0]     total_bits,
   output lpbd_pkg::result_type                      result
);
   import lpbd_pkg::*;

   localparam int LEN_W = MAX_HEADER_BYTES * BITS_PER_BYTE;
   localparam int CNT_W = $clog2(LEN_W + 1);
   localparam int SUM_W = ((LEN_W > TOTAL_BITS_WIDTH) ? LEN_W : TOTAL_BITS_WIDTH) + 1;
   localparam logic [3:0] MAX_BYTES = 4'(MAX_HEADER_BYTES);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_STOPPED = 2'd2
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [TOTAL_BITS_WIDTH-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [TOTAL_BITS_WIDTH-1:0]   rem_ff, rem_in;

   phase_type                     phase_cur;
   logic [TOTAL_BITS_WIDTH-1:0]   pos_cur;
   logic [TOTAL_BITS_WIDTH-1:0]   pos_inc;
   logic [CNT_W-1:0]              cnt_cur;
   logic [CNT_W-1:0]              cnt_inc;
   logic [LEN_W-1:0]              len_base;
   logic [LEN_W-1:0]              len_new;
   logic [TOTAL_BITS_WIDTH-1:0]   rem_cur;
   logic [TOTAL_BITS_WIDTH-1:0]   rem_dec;
   logic [3:0]                    hdr_bytes_ext;
   logic [3:0]                    hdr_bytes_sat;
   logic [CNT_W-1:0]              hdr_bits;
   logic [SUM_W-1:0]              total_x;
   logic [SUM_W-1:0]              len_x;
   logic                          hdr_no_room;
   logic                          len_bad;

   // header width, saturated to the largest supported header
   always_comb begin
      hdr_bytes_ext = {1'b0, header_bytes};
      hdr_bytes_sat = (hdr_bytes_ext > MAX_BYTES) ? MAX_BYTES : hdr_bytes_ext;
      hdr_bits      = CNT_W'({hdr_bytes_sat, 3'b000});
   end

   // a start flag clears the parse state for this bit
   always_comb begin
      phase_cur = req.message_start ? PH_HEADER : phase_ff;
      pos_cur   = req.message_start ? '0 : pos_ff;
      cnt_cur   = req.message_start ? '0 : cnt_ff;
      rem_cur   = req.message_start ? '0 : rem_ff;
      len_base  = (req.message_start || cnt_ff == '0) ? '0 : len_ff;
   end

   // header gather and length checks
   always_comb begin
      pos_inc = pos_cur + TOTAL_BITS_WIDTH'(1);
      cnt_inc = cnt_cur + CNT_W'(1);
      rem_dec = (rem_cur != '0) ? rem_cur - TOTAL_BITS_WIDTH'(1) : rem_cur;
      for (int i = 0; i < LEN_W; i++) begin
         len_new[i] = len_base[i] | (req.data_bit && cnt_cur == CNT_W'(i));
      end
      total_x     = SUM_W'(total_bits);
      len_x       = SUM_W'(len_new);
      hdr_no_room = (hdr_bits == '0) ||
                    (({1'b0, pos_cur} + (TOTAL_BITS_WIDTH+1)'(hdr_bits)) >
                     {1'b0, total_bits});
      len_bad     = (len_new == '0) || (len_x > total_x) ||
                    ((SUM_W'(pos_inc) + len_x) > total_x);
   end

   // next parse state and result
   always_comb begin
      phase_in    = phase_cur;
      pos_in      = pos_cur;
      cnt_in      = cnt_cur;
      len_in      = len_ff;
      rem_in      = rem_cur;
      result      = '0;
      unique case (phase_cur)
         PH_HEADER: begin
            if (cnt_cur == '0 && hdr_no_room) begin
               phase_in = PH_STOPPED;
            end else begin
               pos_in = pos_inc;
               len_in = len_new;
               if (cnt_inc >= hdr_bits) begin
                  cnt_in = '0;
                  if (len_bad) begin
                     phase_in = PH_STOPPED;
                  end else begin
                     rem_in   = len_x[TOTAL_BITS_WIDTH-1:0];
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         PH_PAYLOAD: begin
            pos_in                  = pos_inc;
            rem_in                  = rem_dec;
            result.valid            = accept;
            result.data.payload_bit = req.data_bit;
            result.data.record_last = (rem_dec == '0);
            if (rem_dec == '0) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            // stopped: bits pass without effect until the next start flag
         end
      endcase
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

[rtl/core/length_prefixed_bit_deframer.sv]
// ---------------------------------------------------------------------------
// length_prefixed_bit_deframer
// Splits a serial message into length-prefixed records and passes on the
// payload bits, marking the last bit of each record.
// ---------------------------------------------------------------------------
// Usage:
//   req_valid/req_data carry one message bit per request; message_start
//   marks bit 0 of a message and restarts parsing. Each record is a header
//   of header_bytes*8 bits (header_bytes capped at MAX_HEADER_BYTES), lsb
//   first, followed by that many payload bits. rsp_valid/rsp_data carry one
//   payload bit per response, record_last set on the final bit of a record.
//   Header bits and bits after parsing stops (zero header, record past
//   total_bits, no room for another header) give no response.
//   One request is taken every cycle while req_stall is low. Responses come
//   from the output register. When the receiver stalls, one further
//   response is held in a skid register; req_stall rises only when that
//   skid register is full.
//   csr_we writes header_bytes (index 0) or total_bits (index 1); write only
//   while no request is in flight.
//   Reset clears the parse state as if a message starts with the next bit,
//   sets header_bytes to 1 and total_bits to 0, and empties the output.
// ---------------------------------------------------------------------------
module length_prefixed_bit_deframer #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lpbd_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lpbd_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_we,
   input  lpbd_pkg::csr_index_type                 csr_index,
   input  logic [lpbd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import lpbd_pkg::*;

   logic [HDR_BYTES_WIDTH-1:0]   header_bytes_ff;
   logic [TOTAL_BITS_WIDTH-1:0]  total_bits_ff;

   logic        req_accept;
   logic        rsp_taken;
   result_type  result;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        skid_valid_ff;
   rsp_type     skid_data_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= HDR_BYTES_WIDTH'(1);
         total_bits_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_BYTES: header_bytes_ff <= csr_wdata[HDR_BYTES_WIDTH-1:0];
            CSR_TOTAL_BITS:   total_bits_ff   <= csr_wdata[TOTAL_BITS_WIDTH-1:0];
            default:          ;
         endcase
      end
   end

   // record parser
   lpbd_parser #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req          (req_data),
      .header_bytes (header_bytes_ff),
      .total_bits   (total_bits_ff),
      .result       (result)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_taken) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (!rsp_valid_ff || rsp_taken) begin
            rsp_valid_ff <= result.valid;
         end else if (result.valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_taken) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || rsp_taken) begin
         rsp_data_ff <= result.data;
      end else if (result.valid) begin
         skid_data_ff <= result.data;
      end
   end

`ifndef ASSERT_OFF
   // skid register only fills behind a held output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // parser gives a result only for an accepted request
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> req_accept)
      else $error("parser result without an accepted request");

   // output drains when taken with nothing behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_taken && !skid_valid_ff && !result.valid) |=> !rsp_valid_ff)
      else $error("response repeated after being taken");

   // a held response and a new result fill the skid and block new requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && result.valid) |=> req_stall)
      else $error("result accepted into full output path");
`endif

endmodule

[tb/sv/lpbd_record_checker.sv]
// ---------------------------------------------------------------------------
// lpbd_record_checker
// Watches the request, response and register ports of the deframer, tracks
// the parse of each message bit on its own and compares every response
// against the payload bit and record end that the parse calls for.
// ---------------------------------------------------------------------------
module lpbd_record_checker #(
   parameter int MAX_HEADER_BYTES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  lpbd_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  lpbd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  lpbd_pkg::csr_index_type             csr_index,
   input  logic [lpbd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic                                run_done,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import lpbd_pkg::*;

   typedef enum logic [1:0] {
      PARSE_HEADER  = 2'd0,
      PARSE_PAYLOAD = 2'd1,
      PARSE_STOPPED = 2'd2
   } parse_state_type;

   // register copies
   logic [HDR_BYTES_WIDTH-1:0]  cfg_header_bytes;
   logic [TOTAL_BITS_WIDTH-1:0] cfg_total_bits;

   // parse state, kept wide so no sum can wrap
   parse_state_type parse_state;
   logic [63:0]     msg_position;
   int unsigned     header_bits_seen;
   logic [63:0]     header_length;
   logic [63:0]     bits_left;

   rsp_type expected_payload[$];
   int      errors;
   bit      leftover_checked;

   task automatic restart_parse();
      parse_state      = PARSE_HEADER;
      msg_position     = '0;
      header_bits_seen = 0;
      header_length    = '0;
      bits_left        = '0;
   endtask

   // advance the parse by one message bit, queue a payload bit if one results
   task automatic deframe_bit(input req_type item);
      int          eff_bytes;
      logic [63:0] header_width;
      rsp_type     payload;
      eff_bytes = (cfg_header_bytes > MAX_HEADER_BYTES) ? MAX_HEADER_BYTES
                                                        : int'(cfg_header_bytes);
      header_width = 64'(eff_bytes * BITS_PER_BYTE);
      if (item.message_start) begin
         restart_parse();
      end
      case (parse_state)
         PARSE_HEADER: begin
            // no room for a header, or zero-width header, ends the message
            if (header_bits_seen == 0 &&
                (header_width == 0 ||
                 msg_position + header_width > {32'd0, cfg_total_bits})) begin
               parse_state = PARSE_STOPPED;
            end else begin
               if (header_bits_seen == 0) begin
                  header_length = '0;
               end
               if (item.data_bit) begin
                  header_length[header_bits_seen] = 1'b1;
               end
               header_bits_seen++;
               msg_position++;
               if (header_bits_seen >= header_width) begin
                  header_bits_seen = 0;
                  // zero length or a record past the message end stops parsing
                  if (header_length == 0 ||
                      msg_position + header_length > {32'd0, cfg_total_bits}) begin
                     parse_state = PARSE_STOPPED;
                  end else begin
                     bits_left   = header_length;
                     parse_state = PARSE_PAYLOAD;
                  end
               end
            end
         end
         PARSE_PAYLOAD: begin
            msg_position++;
            if (bits_left > 0) begin
               bits_left--;
            end
            payload.payload_bit = item.data_bit;
            payload.record_last = (bits_left == 0);
            expected_payload.insert(expected_payload.size(), payload);
            if (bits_left == 0) begin
               parse_state = PARSE_HEADER;
            end
         end
         default: begin
         end
      endcase
   endtask

   // compare one response against the oldest expected payload bit
   task automatic check_response(input rsp_type actual);
      rsp_type wanted;
      if (expected_payload.size() == 0) begin
         $error("unexpected response: payload_bit %0b record_last %0b",
                actual.payload_bit, actual.record_last);
         errors++;
      end else begin
         wanted = expected_payload.pop_front();
         if (actual.payload_bit !== wanted.payload_bit) begin
            $error("payload_bit: expected %0b, actual %0b",
                   wanted.payload_bit, actual.payload_bit);
            errors++;
         end
         if (actual.record_last !== wanted.record_last) begin
            $error("record_last: expected %0b, actual %0b",
                   wanted.record_last, actual.record_last);
            errors++;
         end
      end
   endtask

   initial begin
      errors           = 0;
      leftover_checked = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_header_bytes = 3'd1;
         cfg_total_bits   = '0;
         restart_parse();
         expected_payload.delete();
      end else begin
         // register writes land before any request that follows them
         if (csr_we) begin
            if (csr_index == CSR_HEADER_BYTES) begin
               cfg_header_bytes = csr_wdata[HDR_BYTES_WIDTH-1:0];
            end else begin
               cfg_total_bits = csr_wdata[TOTAL_BITS_WIDTH-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            check_response(rsp_data);
         end
         if (req_valid && !req_stall) begin
            deframe_bit(req_data);
         end
         // anything still waiting at the end never arrived
         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_payload.size() != 0) begin
               $error("payload bits never delivered: expected 0, actual %0d",
                      expected_payload.size());
               errors += expected_payload.size();
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_payload.size();
   end

endmodule

[tb/sv/tb_length_prefixed_bit_deframer.sv]
// ---------------------------------------------------------------------------
// tb_length_prefixed_bit_deframer
// Feeds the deframer directed corner messages and then randomly built
// framed messages and noise under several header widths and message
// lengths, with random idling on both channels and one long response
// hold-off. A separate checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb_length_prefixed_bit_deframer;

   timeunit 1ns;
   timeprecision 1ps;

   import lpbd_pkg::*;

   localparam int MAX_HDR_BYTES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int TARGET_ITEMS  = 460;
   localparam int QUIET_ITEMS   = 380;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_we;
   csr_index_type             csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;
   logic                      run_done;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int items_sent  = 0;
   bit idle_on     = 1'b1;
   bit hold_request = 1'b0;

   // bits of the message being built
   req_type frame_bits[$];
   bit      frame_start;

   length_prefixed_bit_deframer #(
      .MAX_HEADER_BYTES(MAX_HDR_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lpbd_record_checker #(
      .MAX_HEADER_BYTES(MAX_HDR_BYTES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .run_done       (run_done),
      .mismatch_count (fail_count),
      .pending_count  (pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: random stall bursts plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one message bit and hold it until taken, then maybe go idle
   task automatic send_req(input logic bit_value, input logic start_flag);
      req_data  <= '{data_bit: bit_value, message_start: start_flag};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // value sent lsb first; start flag on the first bit if asked
   task automatic send_field(input logic [31:0] value, input int nbits,
                             input bit start_first);
      for (int i = 0; i < nbits; i++) begin
         send_req(value[i], start_first && i == 0);
      end
   endtask

   // drain: no request offered, nothing expected, pipeline settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back; header_bytes sometimes carries junk above
   task automatic write_config(input logic [2:0] hdr_bytes, input logic [31:0] total);
      logic [31:0] junk;
      junk = $urandom();
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_BYTES;
      csr_wdata <= ($urandom_range(0, 3) == 0) ? {junk[31:3], hdr_bytes}
                                               : {29'd0, hdr_bytes};
      @(posedge clock);
      csr_index <= CSR_TOTAL_BITS;
      csr_wdata <= total;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic append_bit(input logic bit_value);
      req_type item;
      item.data_bit      = bit_value;
      item.message_start = frame_start && frame_bits.size() == 0;
      frame_bits.insert(frame_bits.size(), item);
   endtask

   task automatic append_noise(input int count);
      for (int i = 0; i < count; i++) begin
         append_bit($urandom_range(0, 1));
      end
   endtask

   // one framed message with random records and a random message length;
   // steady gives a clean 1-byte-header message with long records
   task automatic framed_phase(input bit steady);
      logic [2:0]  hdr_bytes;
      logic [31:0] rec_len;
      logic [31:0] total;
      int          hw;
      int          nrec;
      int          pick;
      int          cut;
      frame_bits.delete();
      pick = $urandom_range(0, 15);
      if (steady) hdr_bytes = 3'd1;
      else if (pick == 0) hdr_bytes = 3'd0;
      else if (pick == 1) hdr_bytes = 3'($urandom_range(5, 7));
      else if (pick == 2) hdr_bytes = 3'd4;
      else if (pick == 3) hdr_bytes = 3'd3;
      else if (pick < 10) hdr_bytes = 3'd1;
      else hdr_bytes = 3'd2;
      hw = ((hdr_bytes > MAX_HDR_BYTES) ? MAX_HDR_BYTES : int'(hdr_bytes)) * BITS_PER_BYTE;
      frame_start = steady || ($urandom_range(0, 7) != 0);
      nrec = steady ? 4 : ((hw == 32) ? $urandom_range(1, 2) : $urandom_range(1, 4));
      if (hw == 0) begin
         append_noise($urandom_range(1, 6));
      end
      for (int r = 0; r < nrec && hw > 0; r++) begin
         pick = $urandom_range(0, 15);
         if (steady) begin
            rec_len = $urandom_range(10, 14);
         end else if (pick == 0) begin
            rec_len = '0;
         end else if (pick == 1) begin
            rec_len = $urandom();
            if (hw < 32) rec_len = rec_len & ((32'd1 << hw) - 32'd1);
         end else begin
            rec_len = $urandom_range(1, 12);
         end
         for (int k = 0; k < hw; k++) begin
            append_bit(rec_len[k]);
         end
         // zero or huge length: two noise bits follow and no further record
         if (rec_len == 0 || rec_len > 64) begin
            append_noise(2);
            break;
         end
         append_noise(rec_len);
      end
      // message length: exact, with slack, short, or extreme
      pick = $urandom_range(0, 9);
      if (steady || pick < 6) total = frame_bits.size();
      else if (pick == 6) total = frame_bits.size() + $urandom_range(1, 8);
      else if (pick == 7) total = (frame_bits.size() > 5) ?
                                  frame_bits.size() - $urandom_range(1, 5) : 0;
      else if (pick == 8) total = 32'hFFFF_FFFF;
      else total = $urandom();
      if (!steady && $urandom_range(0, 2) == 0) begin
         append_noise($urandom_range(1, 6));
      end
      // a cut message leaves the parse mid-record for the next start flag
      cut = frame_bits.size();
      if (!steady && $urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, cut);
      end
      write_config(hdr_bytes, total);
      for (int i = 0; i < cut; i++) begin
         send_req(frame_bits[i].data_bit, frame_bits[i].message_start);
      end
   endtask

   // unframed bits with scattered start flags
   task automatic noise_phase();
      int count;
      count = $urandom_range(20, 40);
      write_config(3'($urandom_range(0, 7)),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom());
      for (int i = 0; i < count; i++) begin
         send_req($urandom_range(0, 1), $urandom_range(0, 11) == 0);
      end
   endtask

   initial begin
      int phase_no;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_HEADER_BYTES;
      csr_wdata <= '0;
      run_done  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no start flag after reset: record of two bits, then no room for a header
      write_config(3'd1, 32'd11);
      send_field(32'd2, 8, 1'b0);
      send_field(32'd1, 2, 1'b0);
      send_req(1'b1, 1'b0);
      wait_idle();

      // zero-width header stops at once
      write_config(3'd0, 32'd100);
      send_req(1'b1, 1'b1);
      wait_idle();

      // oversized header width saturates, still too long for the message
      write_config(3'd7, 32'd31);
      send_req(1'b0, 1'b1);
      wait_idle();

      // zero header with the largest message length
      write_config(3'd1, 32'hFFFF_FFFF);
      send_field(32'd0, 8, 1'b1);
      wait_idle();

      // record would run past the message end
      write_config(3'd1, 32'd8);
      send_field(32'd1, 8, 1'b1);

      // random messages, one long receiver hold-off early on
      phase_no = 0;
      while (items_sent < TARGET_ITEMS) begin
         wait_idle();
         if (items_sent >= QUIET_ITEMS) begin
            idle_on = 1'b0;
         end
         if (phase_no == 1) begin
            hold_request = 1'b1;
            framed_phase(1'b1);
         end else if ($urandom_range(0, 5) == 0) begin
            noise_phase();
         end else begin
            framed_phase(1'b0);
         end
         phase_no++;
      end

      // drain and settle
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
